[hdl/cia402pp_pkg.sv]
package cia402pp_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_TARGET_OFFSET    = 3'd0;
   localparam logic [2:0] CSR_REACH_TOLERANCE  = 3'd1;
   localparam logic [2:0] CSR_PRELOAD_CYCLES   = 3'd2;
   localparam logic [2:0] CSR_FAULT_LOW_CYCLES = 3'd3;
   localparam logic [2:0] CSR_SYNC_HOLD_CYCLES = 3'd4;

   // configuration reset values
   localparam logic [31:0] RST_TARGET_OFFSET    = 32'hFF4F_37E4;
   localparam logic [15:0] RST_REACH_TOLERANCE  = 16'd500;
   localparam logic [7:0]  RST_PRELOAD_CYCLES   = 8'd20;
   localparam logic [7:0]  RST_FAULT_LOW_CYCLES = 8'd10;
   localparam logic [7:0]  RST_SYNC_HOLD_CYCLES = 8'd5;

   // status word bits and decode masks
   localparam logic [15:0] SW_FAULT            = 16'h0008;
   localparam logic [15:0] SW_MASK_DISABLED    = 16'h004F;
   localparam logic [15:0] SW_SWITCH_DISABLED  = 16'h0040;
   localparam logic [15:0] SW_MASK_STATE       = 16'h006F;
   localparam logic [15:0] SW_READY_TO_SWITCH  = 16'h0021;
   localparam logic [15:0] SW_SWITCHED_ON      = 16'h0023;
   localparam logic [15:0] SW_OP_ENABLED       = 16'h0027;
   localparam logic [15:0] SW_TARGET_REACHED   = 16'h0400;
   localparam logic [15:0] SW_SETPOINT_ACK     = 16'h1000;

   // control words
   localparam logic [15:0] CW_ZERO             = 16'h0000;
   localparam logic [15:0] CW_FAULT_RESET      = 16'h0080;
   localparam logic [15:0] CW_SHUTDOWN         = 16'h0006;
   localparam logic [15:0] CW_SWITCH_ON        = 16'h0007;
   localparam logic [15:0] CW_ENABLE_OP        = 16'h000F;
   localparam logic [15:0] CW_NEW_SETPOINT     = 16'h003F;

   // handshake phases
   localparam logic [2:0] PHASE_ARMED   = 3'd0;
   localparam logic [2:0] PHASE_SETPNT  = 3'd1;
   localparam logic [2:0] PHASE_ACKED   = 3'd2;
   localparam logic [2:0] PHASE_WAITMV  = 3'd3;
   localparam logic [2:0] PHASE_MOVING  = 3'd4;

endpackage

[hdl/cia402_profile_position_master.sv]
// response: registered in the output register when its request transaction is accepted
// throughput: one request per cycle; the single output register frees whenever
//   rsp_tready is high, so back-to-back transactions flow without bubbles
// reset: synchronous active-high reset clears all axis state and the output valid,
//   and loads the configuration registers with their default values
module cia402_profile_position_master (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [15:0] status_word, [47:16] actual_position
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] control_word, [47:16] target_position,
                                    // [50:48] motion_phase, [51] target_reached, zero pad
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] target_offset_ff;
   logic [15:0] reach_tolerance_ff;
   logic [7:0]  preload_cycles_ff;
   logic [7:0]  fault_low_cycles_ff;
   logic [7:0]  sync_hold_cycles_ff;

   // axis state
   logic [7:0]  fault_low_count_ff, fault_low_count_in;
   logic        enabled_seen_ff,    enabled_seen_in;
   logic [31:0] final_target_ff,    final_target_in;
   logic [2:0]  phase_ff,           phase_in;
   logic        moved_ff,           moved_in;
   logic [7:0]  preload_count_ff,   preload_count_in;
   logic        reached_ff,         reached_in;
   logic [8:0]  sync_hold_count_ff, sync_hold_count_in;

   // response register
   logic        rsp_valid_ff;
   logic [15:0] cw_ff,  cw_in;
   logic [31:0] tgt_ff, tgt_in;

   logic        accept;
   logic        trigger;
   logic [15:0] sw;
   logic [31:0] pos;
   logic [32:0] pos_err;
   logic [32:0] err_mag;
   logic        in_tolerance;

   assign sw         = req_tdata[15:0];
   assign pos        = req_tdata[47:16];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         target_offset_ff    <= cia402pp_pkg::RST_TARGET_OFFSET;
         reach_tolerance_ff  <= cia402pp_pkg::RST_REACH_TOLERANCE;
         preload_cycles_ff   <= cia402pp_pkg::RST_PRELOAD_CYCLES;
         fault_low_cycles_ff <= cia402pp_pkg::RST_FAULT_LOW_CYCLES;
         sync_hold_cycles_ff <= cia402pp_pkg::RST_SYNC_HOLD_CYCLES;
      end else if (csr_we) begin
         unique case (csr_index)
            cia402pp_pkg::CSR_TARGET_OFFSET:    target_offset_ff    <= csr_wdata;
            cia402pp_pkg::CSR_REACH_TOLERANCE:  reach_tolerance_ff  <= csr_wdata[15:0];
            cia402pp_pkg::CSR_PRELOAD_CYCLES:   preload_cycles_ff   <= csr_wdata[7:0];
            cia402pp_pkg::CSR_FAULT_LOW_CYCLES: fault_low_cycles_ff <= csr_wdata[7:0];
            cia402pp_pkg::CSR_SYNC_HOLD_CYCLES: sync_hold_cycles_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // position error magnitude against the latched target
   // only used in the moving phase, which is reached after the target is latched
   always_comb begin
      pos_err      = {pos[31], pos} - {final_target_ff[31], final_target_ff};
      err_mag      = pos_err[32] ? (33'd0 - pos_err) : pos_err;
      in_tolerance = err_mag <= {17'd0, reach_tolerance_ff};
   end

   // next axis state and response for one status/position transaction
   always_comb begin
      fault_low_count_in = fault_low_count_ff;
      enabled_seen_in    = enabled_seen_ff;
      final_target_in    = final_target_ff;
      phase_in           = phase_ff;
      moved_in           = moved_ff;
      preload_count_in   = preload_count_ff;
      reached_in         = reached_ff;
      sync_hold_count_in = sync_hold_count_ff;
      trigger            = 1'b0;
      tgt_in             = pos;
      cw_in              = cia402pp_pkg::CW_SHUTDOWN;

      // sync hold counter, from the state before this transaction
      priority if (!enabled_seen_ff || (preload_count_ff < preload_cycles_ff)) begin
         sync_hold_count_in = 9'd0;
      end else if (sync_hold_count_ff < {1'b0, sync_hold_cycles_ff}) begin
         sync_hold_count_in = sync_hold_count_ff + 9'd1;
      end else if (sync_hold_count_ff == {1'b0, sync_hold_cycles_ff}) begin
         trigger            = 1'b1;
         sync_hold_count_in = sync_hold_count_ff + 9'd1;
      end else begin
         sync_hold_count_in = sync_hold_count_ff;
      end

      // drive state decode
      priority if ((sw & cia402pp_pkg::SW_FAULT) != 16'd0) begin
         if (fault_low_count_ff < fault_low_cycles_ff) begin
            cw_in              = cia402pp_pkg::CW_ZERO;
            fault_low_count_in = fault_low_count_ff + 8'd1;
         end else begin
            cw_in              = cia402pp_pkg::CW_FAULT_RESET;
            fault_low_count_in = 8'd0;
         end
      end else if ((sw & cia402pp_pkg::SW_MASK_DISABLED) == cia402pp_pkg::SW_SWITCH_DISABLED)
      begin
         cw_in = cia402pp_pkg::CW_SHUTDOWN;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_READY_TO_SWITCH)
      begin
         cw_in = cia402pp_pkg::CW_SWITCH_ON;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_SWITCHED_ON) begin
         cw_in = cia402pp_pkg::CW_ENABLE_OP;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_OP_ENABLED) begin
         // latch the move target on first entry to operation enabled
         if (!enabled_seen_ff) begin
            enabled_seen_in = 1'b1;
            final_target_in = pos + target_offset_ff;
         end
         tgt_in = final_target_in;
         cw_in  = cia402pp_pkg::CW_ENABLE_OP;

         // new set-point handshake
         unique case (phase_ff)
            cia402pp_pkg::PHASE_ARMED: begin
               if (preload_count_ff < preload_cycles_ff) begin
                  preload_count_in = preload_count_ff + 8'd1;
               end else if (trigger) begin
                  cw_in    = cia402pp_pkg::CW_NEW_SETPOINT;
                  phase_in = cia402pp_pkg::PHASE_SETPNT;
               end
            end
            cia402pp_pkg::PHASE_SETPNT: begin
               cw_in = cia402pp_pkg::CW_NEW_SETPOINT;
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 16'd0) moved_in = 1'b1;
               if ((sw & cia402pp_pkg::SW_SETPOINT_ACK) != 16'd0)
                  phase_in = cia402pp_pkg::PHASE_ACKED;
            end
            cia402pp_pkg::PHASE_ACKED: begin
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 16'd0) moved_in = 1'b1;
               if ((sw & cia402pp_pkg::SW_SETPOINT_ACK) == 16'd0)
                  phase_in = moved_in ? cia402pp_pkg::PHASE_MOVING
                                      : cia402pp_pkg::PHASE_WAITMV;
            end
            cia402pp_pkg::PHASE_WAITMV: begin
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 16'd0) begin
                  moved_in = 1'b1;
                  phase_in = cia402pp_pkg::PHASE_MOVING;
               end
            end
            default: begin
               if (((sw & cia402pp_pkg::SW_TARGET_REACHED) != 16'd0) && in_tolerance)
                  reached_in = 1'b1;
            end
         endcase
      end else begin
         cw_in = cia402pp_pkg::CW_SHUTDOWN;
      end
   end

   // axis state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fault_low_count_ff <= 8'd0;
         enabled_seen_ff    <= 1'b0;
         final_target_ff    <= 32'd0;
         phase_ff           <= cia402pp_pkg::PHASE_ARMED;
         moved_ff           <= 1'b0;
         preload_count_ff   <= 8'd0;
         reached_ff         <= 1'b0;
         sync_hold_count_ff <= 9'd0;
      end else if (accept) begin
         fault_low_count_ff <= fault_low_count_in;
         enabled_seen_ff    <= enabled_seen_in;
         final_target_ff    <= final_target_in;
         phase_ff           <= phase_in;
         moved_ff           <= moved_in;
         preload_count_ff   <= preload_count_in;
         reached_ff         <= reached_in;
         sync_hold_count_ff <= sync_hold_count_in;
      end
   end

   // response output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cw_ff  <= cw_in;
         tgt_ff <= tgt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, reached_ff, phase_ff, tgt_ff, cw_ff};

   // phase only moves forward
   a_phase_monotonic: assert property (@(posedge clock) disable iff (reset)
      phase_ff >= $past(phase_ff))
      else $error("handshake phase went backward");

   // target reached is sticky
   a_reached_sticky: assert property (@(posedge clock) disable iff (reset)
      reached_ff |=> reached_ff)
      else $error("target reached flag cleared");

   // an empty output register always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("request stalled with empty output register");

   // reached can only be set in the moving phase
   a_reached_phase: assert property (@(posedge clock) disable iff (reset)
      reached_ff |-> (phase_ff == cia402pp_pkg::PHASE_MOVING))
      else $error("target reached outside moving phase");

endmodule

[dv/cia402_profile_position_master_tb.sv]
module cia402_profile_position_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PHASE_ITEMS = 443;
   // quick stop active: outside every decoded state
   localparam logic [15:0] SW_QUICK_STOP = 16'h0007;

   // request: status_word in the low bits, actual_position above
   typedef struct packed {
      logic [31:0] pos;
      logic [15:0] sw;
   } drive_feedback_type;

   // response: control_word, target_position, motion_phase, target_reached, pad
   typedef struct packed {
      logic [3:0]  pad;
      logic        reached;
      logic [2:0]  phase;
      logic [31:0] tgt;
      logic [15:0] cw;
   } drive_command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   drive_feedback_type feedback_queue[$];
   drive_command_type  command_queue[$];
   int error_count = 0;
   int cycle_count = 0;
   int items_queued = 0;
   int tx_idle_pct = 16;
   int rx_idle_pct = 83;
   bit holdoff_arm = 1'b0;
   bit holdoff_used = 1'b0;
   int hold_left = 0;

   // configuration copy
   logic [31:0] cfg_offset = cia402pp_pkg::RST_TARGET_OFFSET;
   logic [15:0] cfg_tol = cia402pp_pkg::RST_REACH_TOLERANCE;
   logic [7:0]  cfg_preload = cia402pp_pkg::RST_PRELOAD_CYCLES;
   logic [7:0]  cfg_fault_low = cia402pp_pkg::RST_FAULT_LOW_CYCLES;
   logic [7:0]  cfg_sync = cia402pp_pkg::RST_SYNC_HOLD_CYCLES;

   // axis state copy
   logic [7:0]  fault_lo_cnt = '0;
   bit          en_seen = 1'b0;
   logic [31:0] latched_target = '0;
   logic [2:0]  hs_phase = cia402pp_pkg::PHASE_ARMED;
   bit          moved_flag = 1'b0;
   logic [7:0]  preload_ctr = '0;
   bit          reached = 1'b0;
   logic [8:0]  sync_cnt = '0;

   cia402_profile_position_master u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // one process-data cycle of the axis master
   function automatic drive_command_type predict_command(input logic [15:0] sw,
                                                         input logic [31:0] pos);
      drive_command_type r;
      bit fire;
      logic signed [33:0] err;
      logic [33:0] mag;
      r = '0;
      fire = 1'b0;
      r.tgt = pos;
      // sync hold runs on the state from before this cycle
      if (!en_seen || preload_ctr < cfg_preload) begin
         sync_cnt = '0;
      end else if (sync_cnt < cfg_sync) begin
         sync_cnt = sync_cnt + 9'd1;
      end else if (sync_cnt == cfg_sync) begin
         fire = 1'b1;
         sync_cnt = sync_cnt + 9'd1;
      end
      if ((sw & cia402pp_pkg::SW_FAULT) != 0) begin
         if (fault_lo_cnt < cfg_fault_low) begin
            r.cw = cia402pp_pkg::CW_ZERO;
            fault_lo_cnt = fault_lo_cnt + 8'd1;
         end else begin
            r.cw = cia402pp_pkg::CW_FAULT_RESET;
            fault_lo_cnt = '0;
         end
      end else if ((sw & cia402pp_pkg::SW_MASK_DISABLED) == cia402pp_pkg::SW_SWITCH_DISABLED)
      begin
         r.cw = cia402pp_pkg::CW_SHUTDOWN;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_READY_TO_SWITCH)
      begin
         r.cw = cia402pp_pkg::CW_SWITCH_ON;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_SWITCHED_ON) begin
         r.cw = cia402pp_pkg::CW_ENABLE_OP;
      end else if ((sw & cia402pp_pkg::SW_MASK_STATE) == cia402pp_pkg::SW_OP_ENABLED) begin
         // latch the move target on the first enabled cycle only
         if (!en_seen) begin
            en_seen = 1'b1;
            latched_target = pos + cfg_offset;
         end
         r.tgt = latched_target;
         err = $signed({{2{pos[31]}}, pos})
             - $signed({{2{latched_target[31]}}, latched_target});
         mag = err[33] ? -err : err;
         r.cw = cia402pp_pkg::CW_ENABLE_OP;
         case (hs_phase)
            cia402pp_pkg::PHASE_ARMED: begin
               if (preload_ctr < cfg_preload) begin
                  preload_ctr = preload_ctr + 8'd1;
               end else if (fire) begin
                  r.cw = cia402pp_pkg::CW_NEW_SETPOINT;
                  hs_phase = cia402pp_pkg::PHASE_SETPNT;
               end
            end
            cia402pp_pkg::PHASE_SETPNT: begin
               r.cw = cia402pp_pkg::CW_NEW_SETPOINT;
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 0) moved_flag = 1'b1;
               if ((sw & cia402pp_pkg::SW_SETPOINT_ACK) != 0)
                  hs_phase = cia402pp_pkg::PHASE_ACKED;
            end
            cia402pp_pkg::PHASE_ACKED: begin
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 0) moved_flag = 1'b1;
               if ((sw & cia402pp_pkg::SW_SETPOINT_ACK) == 0)
                  hs_phase = moved_flag ? cia402pp_pkg::PHASE_MOVING
                                        : cia402pp_pkg::PHASE_WAITMV;
            end
            cia402pp_pkg::PHASE_WAITMV: begin
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) == 0) begin
                  moved_flag = 1'b1;
                  hs_phase = cia402pp_pkg::PHASE_MOVING;
               end
            end
            default: begin
               if ((sw & cia402pp_pkg::SW_TARGET_REACHED) != 0 && mag <= {18'd0, cfg_tol})
                  reached = 1'b1;
            end
         endcase
      end else begin
         r.cw = cia402pp_pkg::CW_SHUTDOWN;
      end
      r.phase = hs_phase;
      r.reached = reached;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %h, expected %h at cycle %0d",
               what, got, want, cycle_count);
   endtask

   // request driver: holds an item until accepted, then offers the next
   always @(posedge clock) begin : drive_requests
      bit accepted;
      drive_feedback_type fb;
      if (!reset) begin
         accepted = req_tvalid && req_tready;
         if (accepted) begin
            fb = req_tdata;
            command_queue.push_back(predict_command(fb.sw, fb.pos));
            void'(feedback_queue.pop_front());
         end
         if (!req_tvalid || accepted) begin
            if (feedback_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= feedback_queue[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, armed once
   always @(posedge clock) begin
      if (holdoff_arm && !holdoff_used) begin
         hold_left <= HOLDOFF_CYCLES;
         holdoff_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
   end

   // response checker
   always @(posedge clock) begin : check_commands
      drive_command_type got;
      drive_command_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (command_queue.size() == 0) begin
            report_mismatch("response with none outstanding", got.tgt, 32'h0);
         end else begin
            want = command_queue.pop_front();
            if (got.cw !== want.cw)
               report_mismatch("control_word", 32'(got.cw), 32'(want.cw));
            if (got.tgt !== want.tgt)
               report_mismatch("target_position", got.tgt, want.tgt);
            if (got.phase !== want.phase)
               report_mismatch("motion_phase", 32'(got.phase), 32'(want.phase));
            if (got.reached !== want.reached)
               report_mismatch("target_reached", 32'(got.reached), 32'(want.reached));
            if (got.pad !== want.pad)
               report_mismatch("pad bits", 32'(got.pad), 32'(want.pad));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("cia402_profile_position_master_tb: errors");
         $finish;
      end
   end

   function automatic logic [15:0] state_word(input logic [15:0] mask,
                                              input logic [15:0] value);
      return (16'($urandom()) & ~mask) | value;
   endfunction

   // mostly near the latched target once it exists, else anywhere
   function automatic logic [31:0] pick_position();
      int span;
      span = int'(cfg_tol) + 8;
      if (en_seen && $urandom_range(9) < 7)
         return latched_target + 32'($urandom_range(0, 2 * span) - span);
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   task automatic push_item(input logic [15:0] sw, input logic [31:0] pos);
      drive_feedback_type fb;
      fb.sw = sw;
      fb.pos = pos;
      feedback_queue.push_back(fb);
      items_queued++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         cia402pp_pkg::CSR_TARGET_OFFSET:    cfg_offset = val;
         cia402pp_pkg::CSR_REACH_TOLERANCE:  cfg_tol = val[15:0];
         cia402pp_pkg::CSR_PRELOAD_CYCLES:   cfg_preload = val[7:0];
         cia402pp_pkg::CSR_FAULT_LOW_CYCLES: cfg_fault_low = val[7:0];
         cia402pp_pkg::CSR_SYNC_HOLD_CYCLES: cfg_sync = val[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] offset, input logic [15:0] tol,
                            input logic [7:0] preload, input logic [7:0] fault_low,
                            input logic [7:0] sync_hold);
      write_csr(cia402pp_pkg::CSR_TARGET_OFFSET, offset);
      write_csr(cia402pp_pkg::CSR_REACH_TOLERANCE, {16'd0, tol});
      write_csr(cia402pp_pkg::CSR_PRELOAD_CYCLES, {24'd0, preload});
      write_csr(cia402pp_pkg::CSR_FAULT_LOW_CYCLES, {24'd0, fault_low});
      write_csr(cia402pp_pkg::CSR_SYNC_HOLD_CYCLES, {24'd0, sync_hold});
   endtask

   // drain everything in flight, then wait out a settling margin
   task automatic wait_idle();
      do @(negedge clock);
      while (feedback_queue.size() != 0 || req_tvalid || command_queue.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   // drive bring-up: fault, shutdown, switch on, enable, with optional breaks
   task automatic queue_session(input bit broken);
      int n;
      if (!broken || $urandom_range(1)) begin
         n = ($urandom_range(7) == 0) ? int'(cfg_fault_low) + 1 : $urandom_range(0, 6);
         repeat (n)
            push_item(state_word(cia402pp_pkg::SW_FAULT, cia402pp_pkg::SW_FAULT),
                      pick_position());
      end
      if (!broken || $urandom_range(1))
         repeat ($urandom_range(1, 3))
            push_item(state_word(cia402pp_pkg::SW_MASK_DISABLED,
                                 cia402pp_pkg::SW_SWITCH_DISABLED), pick_position());
      if (!broken || $urandom_range(1))
         repeat ($urandom_range(1, 3))
            push_item(state_word(cia402pp_pkg::SW_MASK_STATE,
                                 cia402pp_pkg::SW_READY_TO_SWITCH), pick_position());
      if (!broken || $urandom_range(1))
         repeat ($urandom_range(1, 3))
            push_item(state_word(cia402pp_pkg::SW_MASK_STATE,
                                 cia402pp_pkg::SW_SWITCHED_ON), pick_position());
      if (broken && $urandom_range(1))
         push_item(state_word(cia402pp_pkg::SW_MASK_STATE, SW_QUICK_STOP), pick_position());
      repeat ($urandom_range(4, 60))
         push_item(state_word(cia402pp_pkg::SW_MASK_STATE, cia402pp_pkg::SW_OP_ENABLED),
                   pick_position());
   endtask

   task automatic run_phase(input int budget);
      int first;
      int pick;
      first = items_queued;
      while (items_queued - first < budget) begin
         while (feedback_queue.size() > 4) @(negedge clock);
         pick = $urandom_range(99);
         if (pick < 70) begin
            queue_session(1'b0);
         end else if (pick < 85) begin
            queue_session(1'b1);
         end else begin
            repeat ($urandom_range(3, 15)) push_item(16'($urandom()), $urandom());
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // decode of every state, field extremes, fault low count
      push_item(16'h0000, 32'h0000_0000);
      push_item(16'hFFFF, 32'hFFFF_FFFF);
      push_item(cia402pp_pkg::SW_FAULT, 32'h8000_0000);
      push_item(cia402pp_pkg::SW_FAULT, 32'h7FFF_FFFF);
      wait_idle();
      // limit lowered under the running count: pulse at once
      write_csr(cia402pp_pkg::CSR_FAULT_LOW_CYCLES, 32'd2);
      push_item(cia402pp_pkg::SW_FAULT, 32'h0000_0001);
      push_item(cia402pp_pkg::SW_FAULT, 32'h0000_0002);
      push_item(cia402pp_pkg::SW_FAULT, 32'h0000_0003);
      push_item(cia402pp_pkg::SW_FAULT, 32'h0000_0004);
      wait_idle();
      write_csr(cia402pp_pkg::CSR_FAULT_LOW_CYCLES, 32'd0);
      push_item(cia402pp_pkg::SW_FAULT, 32'h1234_5678);
      push_item(cia402pp_pkg::SW_SWITCH_DISABLED, 32'h0000_0010);
      push_item(16'hFFFF & ~cia402pp_pkg::SW_MASK_DISABLED | cia402pp_pkg::SW_SWITCH_DISABLED,
                32'hFFFF_FFF0);
      push_item(cia402pp_pkg::SW_READY_TO_SWITCH, 32'h0000_0020);
      push_item(16'hFFFF & ~cia402pp_pkg::SW_MASK_STATE | cia402pp_pkg::SW_READY_TO_SWITCH,
                32'h8000_0001);
      push_item(cia402pp_pkg::SW_SWITCHED_ON, 32'h0000_0030);
      push_item(SW_QUICK_STOP, 32'h7FFF_FFFE);
      push_item(16'h0003, 32'h0000_0040);
      wait_idle();

      // enable with a wrapping target, handshake through the wait-for-motion path
      write_all(32'h7FFF_FFFF, 16'hFFFF, 8'd1, 8'd0, 8'd0);
      push_item(cia402pp_pkg::SW_OP_ENABLED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED | cia402pp_pkg::SW_SETPOINT_ACK
                | cia402pp_pkg::SW_TARGET_REACHED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED | cia402pp_pkg::SW_TARGET_REACHED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED | cia402pp_pkg::SW_TARGET_REACHED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_OP_ENABLED | cia402pp_pkg::SW_TARGET_REACHED, 32'h7FFF_FFF0);
      push_item(cia402pp_pkg::SW_SWITCHED_ON, 32'h0000_0000);
      wait_idle();

      // slow receiver, high limits and zero tolerance
      write_all($urandom(), 16'd0, 8'd255, 8'd255, 8'd255);
      run_phase(PHASE_ITEMS);
      wait_idle();

      // slow sender, low limits and widest tolerance
      tx_idle_pct = 83;
      rx_idle_pct = 16;
      write_all(32'h8000_0000, 16'hFFFF, 8'd0, 8'd0, 8'd0);
      run_phase(PHASE_ITEMS);
      wait_idle();

      // full rate with one long receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      write_all($urandom(), 16'($urandom_range(0, 2000)), 8'($urandom_range(0, 30)),
                8'($urandom_range(0, 20)), 8'($urandom_range(0, 30)));
      holdoff_arm = 1'b1;
      run_phase(PHASE_ITEMS);
      wait_idle();

      if (error_count == 0) begin
         $display("cia402_profile_position_master_tb: clean");
      end else begin
         $display("cia402_profile_position_master_tb: errors");
      end
      $finish;
   end

endmodule
